// ===== rtl/bctt_pkg.sv =====
// Package for the per-block CRC-32C table tracker.
// Holds the item structs, the request and register codes, the sequencer states
// and the CRC byte step. It depends on nothing else.
package bctt_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_ZERO  = 2'd2;
    localparam logic [1:0] FUNC_TRUNC = 2'd3;

    localparam logic [1:0] CFG_BLOCK_SHIFT = 2'd0;
    localparam logic [1:0] CFG_CRC_SEED    = 2'd1;
    localparam logic [1:0] CFG_ZERO_CRC    = 2'd2;

    localparam logic [4:0]  SHIFT_MAX     = 5'd16;
    localparam logic [4:0]  SHIFT_RESET   = 5'd12;
    localparam logic [10:0] MISMATCH_MAX  = 11'd2047;
    localparam logic [31:0] CRC_POLY      = 32'h82F6_3B78;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] start_offset;
        logic [31:0] byte_count;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  done_kind;
        logic [10:0] mismatch_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_WALK,
        S_BYTE,
        S_CMP,
        S_EMIT
    } t_state;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/bctt_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; it uses no package.
module bctt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bctt_out_stage.sv =====
// Output register for result items of the CRC table tracker.
// Holds one result until the receiver takes it; uses bctt_pkg for the item type.
module bctt_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bctt_pkg::t_out_item i_item,
    input  logic                i_stall,
    output logic                o_valid,
    output bctt_pkg::t_out_item o_item,
    output logic                o_free
);

    logic                r_valid;
    bctt_pkg::t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_free  = !r_valid || !i_stall;

endmodule

// ===== rtl/block_crc_table_tracker_core.sv =====
// Per-block CRC-32C table tracker, top level.
// Uses bctt_pkg, bctt_ram for the entry table and bctt_out_stage for results.
//
// Input items arrive on i_in_valid / o_in_stall with the payload in i_in_item;
// one item carries at most one payload byte. The first item of a request
// supplies func, start offset and byte count; the item with is_last ends it.
// Results leave on o_out_valid / i_out_stall, one per request, after is_last.
// The table sits in one RAM of NUM_BLOCKS entries (CRC plus valid bit) with a
// registered read, and a sequencer reads, modifies and writes it.
// A payload item passes the byte state, then the compare state when it completes
// a block of a read (table read before the compare). The opening item first
// passes the head and tail states for the edge blocks, and zero or truncate
// then walk the table entries one at a time and end the walk.
// After the last item the emit state loads the output register, which then holds
// the result while the next request already starts.
// After reset the block clears every valid bit, one entry per cycle, and
// accepts no item then. Configuration writes on i_cfg_we are taken at any
// time and are expected only while idle.
// A stalled receiver holds the result; the block stops only when a second
// result is ready and the output register is still full.
module block_crc_table_tracker_core #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bctt_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bctt_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = IW + 1;
    localparam logic [32:0]   NB33 = 33'(NUM_BLOCKS);
    localparam logic [CW-1:0] NBCW = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] LAST = CW'(NUM_BLOCKS - 1);

    bctt_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_clr, n_clr;
    logic          r_busy, n_busy;
    logic [4:0]    r_cfg_shift;
    logic [31:0]   r_cfg_seed;
    logic [31:0]   r_cfg_zcrc;

    logic [1:0]    r_func, n_func;
    logic [4:0]    r_shift, n_shift;
    logic [32:0]   r_start, n_start;
    logic [32:0]   r_end, n_end;
    logic [32:0]   r_pos, n_pos;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_crc, n_crc;
    logic [10:0]   r_mism, n_mism;
    logic [CW-1:0] r_walk, n_walk;
    logic [CW-1:0] r_walk_end, n_walk_end;
    logic          r_open, n_open;
    logic [7:0]    r_byte, n_byte;
    logic          r_dv, n_dv;
    logic          r_last, n_last;

    logic          w_in_acc;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [32:0]   w_wdata;
    logic [IW-1:0] w_raddr;
    logic [32:0]   w_rdata;
    logic          w_load;
    logic          w_out_free;
    bctt_pkg::t_out_item w_res;

    logic [32:0] w_mask;
    logic [32:0] w_first_whole;
    logic [32:0] w_head_blk;
    logic [32:0] w_tail_blk;
    logic [32:0] w_lo;
    logic [32:0] w_hi;
    logic [32:0] w_off;
    logic [32:0] w_bstart;
    logic [33:0] w_bend;
    logic [32:0] w_idx;
    logic        w_whole;
    logic        w_inr;
    logic        w_full;
    logic [31:0] w_crc_in;
    logic [31:0] w_crc_new;
    logic        w_edge_fn;

    assign o_in_stall = (r_state != bctt_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_mask        = (33'd1 << r_shift) - 33'd1;
    assign w_first_whole = (r_start + w_mask) & ~w_mask;
    assign w_head_blk    = r_start >> r_shift;
    assign w_tail_blk    = r_end >> r_shift;
    assign w_lo          = (r_func == bctt_pkg::FUNC_ZERO) ? (w_first_whole >> r_shift)
                                                           : w_head_blk;
    assign w_hi          = (r_func == bctt_pkg::FUNC_ZERO) ? w_tail_blk : NB33;
    assign w_off         = r_pos & w_mask;
    assign w_bstart      = r_pos & ~w_mask;
    assign w_bend        = {1'b0, w_bstart} + {1'b0, w_mask} + 34'd1;
    assign w_whole       = (w_bstart >= r_start) && (w_bend <= {1'b0, r_end});
    assign w_idx         = r_pos >> r_shift;
    assign w_inr         = (w_idx < NB33);
    assign w_full        = (w_off == w_mask) && w_whole && w_inr;
    assign w_crc_in      = (w_off == 33'd0) ? r_cfg_seed : r_crc;
    assign w_crc_new     = bctt_pkg::crc_byte(w_crc_in, r_byte);
    assign w_edge_fn     = r_open && ((r_func == bctt_pkg::FUNC_WRITE)
                                   || (r_func == bctt_pkg::FUNC_ZERO));

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_busy     = r_busy;
        n_func     = r_func;
        n_shift    = r_shift;
        n_start    = r_start;
        n_end      = r_end;
        n_pos      = r_pos;
        n_rem      = r_rem;
        n_crc      = r_crc;
        n_mism     = r_mism;
        n_walk     = r_walk;
        n_walk_end = r_walk_end;
        n_open     = r_open;
        n_byte     = r_byte;
        n_dv       = r_dv;
        n_last     = r_last;
        w_we       = 1'b0;
        w_waddr    = w_idx[IW-1:0];
        w_wdata    = 33'd0;
        w_raddr    = w_idx[IW-1:0];
        w_load     = 1'b0;
        w_res.done_kind      = r_func;
        w_res.mismatch_count = (r_func == bctt_pkg::FUNC_READ) ? r_mism : 11'd0;

        unique case (r_state)
            bctt_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr[IW-1:0];
                n_clr   = r_clr + CW'(1);
                if (r_clr == LAST) begin
                    n_state = bctt_pkg::S_IDLE;
                end
            end
            bctt_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_byte = i_in_item.data_byte;
                    n_dv   = i_in_item.data_valid;
                    n_last = i_in_item.is_last;
                    n_open = !r_busy;
                    if (!r_busy) begin
                        n_busy  = 1'b1;
                        n_func  = i_in_item.func;
                        n_shift = r_cfg_shift;
                        n_start = {1'b0, i_in_item.start_offset};
                        n_end   = {1'b0, i_in_item.start_offset}
                                + {1'b0, i_in_item.byte_count};
                        n_pos   = {1'b0, i_in_item.start_offset};
                        n_rem   = i_in_item.byte_count;
                        n_mism  = 11'd0;
                        n_state = bctt_pkg::S_HEAD;
                    end else begin
                        n_state = bctt_pkg::S_BYTE;
                    end
                end
            end
            bctt_pkg::S_HEAD: begin
                w_waddr = w_head_blk[IW-1:0];
                w_we    = w_edge_fn && ((r_start & w_mask) != 33'd0) && (w_head_blk < NB33);
                n_state = bctt_pkg::S_TAIL;
            end
            bctt_pkg::S_TAIL: begin
                w_waddr = w_tail_blk[IW-1:0];
                w_we    = w_edge_fn && ((r_end & w_mask) != 33'd0)
                       && ((r_end & ~w_mask) >= w_first_whole) && (w_tail_blk < NB33);
                n_walk     = (w_lo < NB33) ? w_lo[CW-1:0] : NBCW;
                n_walk_end = (w_hi < NB33) ? w_hi[CW-1:0] : NBCW;
                if ((r_func == bctt_pkg::FUNC_ZERO) || (r_func == bctt_pkg::FUNC_TRUNC)) begin
                    n_state = bctt_pkg::S_WALK;
                end else begin
                    n_state = bctt_pkg::S_BYTE;
                end
            end
            bctt_pkg::S_WALK: begin
                w_waddr = r_walk[IW-1:0];
                w_wdata = (r_func == bctt_pkg::FUNC_ZERO) ? {1'b1, r_cfg_zcrc} : 33'd0;
                if (r_walk < r_walk_end) begin
                    w_we   = 1'b1;
                    n_walk = r_walk + CW'(1);
                end else begin
                    n_state = bctt_pkg::S_BYTE;
                end
            end
            bctt_pkg::S_BYTE: begin
                n_state = r_last ? bctt_pkg::S_EMIT : bctt_pkg::S_IDLE;
                if (r_last) begin
                    n_busy = 1'b0;
                end
                if ((r_func[1] == 1'b0) && r_dv && (r_rem != 32'd0)) begin
                    n_crc = w_crc_new;
                    n_pos = r_pos + 33'd1;
                    n_rem = r_rem - 32'd1;
                    if (r_func == bctt_pkg::FUNC_WRITE) begin
                        if (w_full) begin
                            w_we    = 1'b1;
                            w_wdata = {1'b1, w_crc_new};
                        end else if ((w_off == 33'd0) && w_whole && w_inr) begin
                            w_we = 1'b1;
                        end
                    end else if (w_full) begin
                        n_state = bctt_pkg::S_CMP;
                    end
                end
            end
            bctt_pkg::S_CMP: begin
                if (w_rdata[32] && (w_rdata[31:0] != r_crc)
                        && (r_mism != bctt_pkg::MISMATCH_MAX)) begin
                    n_mism = r_mism + 11'd1;
                end
                n_state = r_last ? bctt_pkg::S_EMIT : bctt_pkg::S_IDLE;
            end
            bctt_pkg::S_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = bctt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bctt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bctt_pkg::S_CLEAR;
            r_clr       <= '0;
            r_busy      <= 1'b0;
            r_cfg_shift <= bctt_pkg::SHIFT_RESET;
            r_cfg_seed  <= 32'd0;
            r_cfg_zcrc  <= 32'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_busy  <= n_busy;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bctt_pkg::CFG_BLOCK_SHIFT: begin
                        r_cfg_shift <= (i_cfg_wdata[4:0] > bctt_pkg::SHIFT_MAX)
                                     ? bctt_pkg::SHIFT_MAX : i_cfg_wdata[4:0];
                    end
                    bctt_pkg::CFG_CRC_SEED: begin
                        r_cfg_seed <= i_cfg_wdata;
                    end
                    bctt_pkg::CFG_ZERO_CRC: begin
                        r_cfg_zcrc <= i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_shift    <= n_shift;
        r_start    <= n_start;
        r_end      <= n_end;
        r_pos      <= n_pos;
        r_rem      <= n_rem;
        r_crc      <= n_crc;
        r_mism     <= n_mism;
        r_walk     <= n_walk;
        r_walk_end <= n_walk_end;
        r_open     <= n_open;
        r_byte     <= n_byte;
        r_dv       <= n_dv;
        r_last     <= n_last;
    end

    bctt_ram #(
        .WIDTH(33),
        .DEPTH(NUM_BLOCKS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    bctt_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_load),
        .i_item (w_res),
        .i_stall(i_out_stall),
        .o_valid(o_out_valid),
        .o_item (o_out_item),
        .o_free (w_out_free)
    );

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bctt_pkg::S_CLEAR) |-> o_in_stall)
        else $error("item accepted during table clear");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded into a full output register");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bctt_pkg::S_CMP) |-> ($past(r_state) == bctt_pkg::S_BYTE))
        else $error("compare without a preceding table read");

    a_no_write_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bctt_pkg::S_CMP) |-> !w_we)
        else $error("table written during compare");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for block_crc_table_tracker_core: a short directed table, then random requests.
// A predictor of the CRC table checks every result that a row does not give itself. Depends on bctt_pkg and the RTL.
module testbench;

    localparam int TABLE_SIZE = 1024;

    typedef struct {
        bctt_pkg::t_in_item  it;
        bit                  typed;
        bctt_pkg::t_out_item want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;
    bctt_pkg::t_in_item  i_in_item = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    bctt_pkg::t_out_item o_out_item;

    logic [4:0]      cur_shift = bctt_pkg::SHIFT_RESET;
    logic [31:0]     cur_seed = '0;
    logic [31:0]     cur_zero_crc = '0;
    logic [31:0]     tbl_crc [TABLE_SIZE];
    bit              tbl_valid [TABLE_SIZE];
    bit              req_open = 0;
    logic [1:0]      req_kind;
    int unsigned     req_shift;
    longint unsigned req_lo, req_hi, pos, left;
    logic [31:0]     crc_acc;
    logic [10:0]     bad_blocks;

    bctt_pkg::t_out_item pending_results [$];
    t_row      rows [$];
    logic [7:0] last_data [$];
    longint unsigned last_start, last_count;
    bit        have_write = 0;
    bit        hold_req = 0;
    int        errors = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        phases = 0;

    always #1 i_clk = ~i_clk;

    block_crc_table_tracker_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ bctt_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void invalidate(input longint unsigned blk);
        if (blk < TABLE_SIZE) tbl_valid[blk] = 0;
    endfunction

    function automatic void drop_edges(input longint unsigned m);
        longint unsigned first_whole;
        first_whole = (req_lo + m) & ~m;
        if ((req_lo & m) != 0) invalidate(req_lo >> req_shift);
        if ((req_hi & m) != 0 && (req_hi & ~m) >= first_whole) invalidate(req_hi >> req_shift);
    endfunction

    function automatic void hash_byte(input logic [7:0] b);
        longint unsigned m, off, bstart, idx;
        bit whole;
        m = (64'd1 << req_shift) - 1;
        off = pos & m;
        bstart = pos - off;
        whole = bstart >= req_lo && bstart + m + 1 <= req_hi;
        idx = pos >> req_shift;
        if (off == 0) begin
            crc_acc = cur_seed;
            if (req_kind == bctt_pkg::FUNC_WRITE && whole) invalidate(idx);
        end
        crc_acc = crc_step(crc_acc, b);
        if (off == m && whole && idx < TABLE_SIZE) begin
            if (req_kind == bctt_pkg::FUNC_WRITE) begin
                tbl_crc[idx] = crc_acc;
                tbl_valid[idx] = 1;
            end else if (tbl_valid[idx] && tbl_crc[idx] != crc_acc) begin
                if (bad_blocks != bctt_pkg::MISMATCH_MAX) bad_blocks++;
            end
        end
        pos++;
        left--;
    endfunction

    function automatic void predict_item(input bctt_pkg::t_in_item it, output bit produced,
                                         output bctt_pkg::t_out_item got);
        longint unsigned m, lo, hi;
        produced = 0;
        got = '0;
        if (!req_open) begin
            req_kind = it.func;
            req_lo = it.start_offset;
            req_hi = req_lo + it.byte_count;
            req_shift = cur_shift;
            pos = req_lo;
            left = it.byte_count;
            bad_blocks = '0;
            req_open = 1;
            m = (64'd1 << req_shift) - 1;
            if (req_kind == bctt_pkg::FUNC_WRITE) begin
                drop_edges(m);
            end else if (req_kind == bctt_pkg::FUNC_ZERO) begin
                lo = ((req_lo + m) & ~m) >> req_shift;
                hi = (req_hi & ~m) >> req_shift;
                drop_edges(m);
                for (longint unsigned k = lo; k < hi && k < TABLE_SIZE; k++) begin
                    tbl_crc[k] = cur_zero_crc;
                    tbl_valid[k] = 1;
                end
            end else if (req_kind == bctt_pkg::FUNC_TRUNC) begin
                for (longint unsigned k = req_lo >> req_shift; k < TABLE_SIZE; k++)
                    tbl_valid[k] = 0;
            end
        end
        if (req_kind <= bctt_pkg::FUNC_READ && it.data_valid && left > 0)
            hash_byte(it.data_byte);
        if (it.is_last) begin
            req_open = 0;
            produced = 1;
            got.done_kind = req_kind;
            got.mismatch_count = (req_kind == bctt_pkg::FUNC_READ) ? bad_blocks : 11'd0;
        end
    endfunction

    function automatic bctt_pkg::t_in_item mk(input logic [1:0] f, input logic [31:0] s,
                                              input logic [31:0] c, input logic [7:0] b,
                                              input logic dv, input logic last);
        bctt_pkg::t_in_item it;
        it.func = f;
        it.start_offset = s;
        it.byte_count = c;
        it.data_byte = b;
        it.data_valid = dv;
        it.is_last = last;
        return it;
    endfunction

    function automatic bctt_pkg::t_out_item res(input logic [1:0] k, input logic [10:0] n);
        bctt_pkg::t_out_item r;
        r.done_kind = k;
        r.mismatch_count = n;
        return r;
    endfunction

    task automatic add_row(input bctt_pkg::t_in_item it, input bit typed,
                           input bctt_pkg::t_out_item want);
        t_row r;
        r.it = it;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endtask

    task automatic send_item(input bctt_pkg::t_in_item it, input bit typed,
                             input bctt_pkg::t_out_item want);
        int gap;
        bit produced;
        bctt_pkg::t_out_item got;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            9:             gap = $urandom_range(5, 30);
            default:       gap = $urandom_range(1, 3);
        endcase
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(it, produced, got);
        if (produced) pending_results.insert(pending_results.size(), typed ? want : got);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == bctt_pkg::CFG_BLOCK_SHIFT)
            cur_shift = (val[4:0] > bctt_pkg::SHIFT_MAX) ? bctt_pkg::SHIFT_MAX : val[4:0];
        else if (idx == bctt_pkg::CFG_CRC_SEED) cur_seed = val;
        else if (idx == bctt_pkg::CFG_ZERO_CRC) cur_zero_crc = val;
    endtask

    task automatic random_request();
        logic [1:0] kind;
        longint unsigned m, start, count;
        int nbytes, nblk;
        bit reuse, flip;
        logic [7:0] b;
        bctt_pkg::t_in_item it;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6:        kind = bctt_pkg::FUNC_WRITE;
            7, 8, 9, 10, 11, 12, 13:    kind = bctt_pkg::FUNC_READ;
            14, 15, 16:                 kind = bctt_pkg::FUNC_ZERO;
            default:                    kind = bctt_pkg::FUNC_TRUNC;
        endcase
        m = (64'd1 << cur_shift) - 1;
        reuse = kind == bctt_pkg::FUNC_READ && have_write && $urandom_range(0, 1);
        flip = 0;
        if ($urandom_range(0, 9) == 0) begin
            start = $urandom;
            count = $urandom;
            reuse = 0;
        end else if (reuse) begin
            start = last_start;
            count = last_count;
            flip = $urandom_range(0, 3) == 0;
        end else begin
            nblk = $urandom_range(0, (cur_shift < 5) ? (48 >> cur_shift) : 2);
            start = longint'($urandom_range(0, 1100)) << cur_shift;
            if ($urandom_range(0, 2) == 0) start += $urandom_range(0, int'(m));
            count = longint'(nblk) << cur_shift;
            if ($urandom_range(0, 2) == 0) count += $urandom_range(0, int'(m));
            start &= 64'hFFFF_FFFF;
            count &= 64'hFFFF_FFFF;
        end
        if (kind <= bctt_pkg::FUNC_READ) begin
            nbytes = (count > 48) ? 48 : int'(count);
            case ($urandom_range(0, 9))
                0: nbytes = $urandom_range(0, nbytes);
                1: nbytes += 2;
                default: ;
            endcase
        end else begin
            nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        end
        if (kind == bctt_pkg::FUNC_WRITE) begin
            last_data.delete();
            last_start = start;
            last_count = count;
            have_write = 1;
        end
        it = mk(kind, start[31:0], count[31:0], 8'h00, 1'b0, nbytes == 0);
        for (int i = 0; i <= nbytes; i++) begin
            if (i > 0) begin
                it.func = 2'($urandom);
                it.start_offset = $urandom;
                it.byte_count = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    it.data_valid = 1'b0;
                    it.is_last = 1'b0;
                    it.data_byte = 8'($urandom);
                    send_item(it, 0, '0);
                end
            end
            if (i == 0 && nbytes > 0 && $urandom_range(0, 1)) begin
                it.data_valid = 1'b0;
                it.data_byte = 8'($urandom);
                send_item(it, 0, '0);
            end
            if (nbytes == 0) begin
                send_item(it, 0, '0);
                break;
            end
            if (i == nbytes) break;
            b = (reuse && i < last_data.size()) ? last_data[i] : 8'($urandom);
            if (flip && i == nbytes / 2) b = ~b;
            if (kind == bctt_pkg::FUNC_WRITE) last_data.insert(last_data.size(), b);
            it.data_byte = b;
            it.data_valid = 1'b1;
            it.is_last = i == nbytes - 1;
            send_item(it, 0, '0);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        bctt_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result arrived with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.done_kind !== want.done_kind)
                    report_mismatch($sformatf("done_kind %0d, want %0d",
                                              o_out_item.done_kind, want.done_kind));
                if (o_out_item.mismatch_count !== want.mismatch_count)
                    report_mismatch($sformatf("mismatch_count %0d, want %0d",
                                              o_out_item.mismatch_count, want.mismatch_count));
            end
        end
    end

    initial begin : out_stall_drive
        bit v;
        int span;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                v = 1;
                span = 400;
            end else begin
                v = $urandom_range(0, 9) < 3;
                span = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 4);
            end
            i_out_stall <= v;
            repeat (span) @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [4:0] shift_plan [10];
        shift_plan = '{5'd0, 5'd1, 5'd3, 5'd2, 5'd31, 5'd4, 5'd0, 5'd5, 5'd16, 5'd2};
        for (int k = 0; k < TABLE_SIZE; k++) begin
            tbl_crc[k] = '0;
            tbl_valid[k] = 0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(mk(bctt_pkg::FUNC_TRUNC, 32'd0, 32'd0, 8'h00, 1'b0, 1'b1), 1,
                res(bctt_pkg::FUNC_TRUNC, 11'd0));
        add_row(mk(bctt_pkg::FUNC_ZERO, 32'd0, 32'd0, 8'h00, 1'b0, 1'b1), 1,
                res(bctt_pkg::FUNC_ZERO, 11'd0));
        for (int i = 0; i < 4; i++)
            add_row(mk(bctt_pkg::FUNC_WRITE, 32'd0, 32'd4, 8'(8'h11 * i), 1'b1, i == 3),
                    0, '0);
        for (int i = 0; i < 4; i++)
            add_row(mk(bctt_pkg::FUNC_READ, 32'd0, 32'd4, 8'(8'h11 * i), 1'b1, i == 3),
                    i == 3, res(bctt_pkg::FUNC_READ, 11'd0));
        for (int i = 0; i < 4; i++)
            add_row(mk(bctt_pkg::FUNC_READ, 32'd0, 32'd4,
                       (i == 2) ? 8'hFF : 8'(8'h11 * i), 1'b1, i == 3),
                    i == 3, res(bctt_pkg::FUNC_READ, 11'd1));
        add_row(mk(bctt_pkg::FUNC_ZERO, 32'd2, 32'd12, 8'h00, 1'b0, 1'b1), 1,
                res(bctt_pkg::FUNC_ZERO, 11'd0));
        add_row(mk(bctt_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1), 1,
                res(bctt_pkg::FUNC_WRITE, 11'd0));
        add_row(mk(bctt_pkg::FUNC_READ, 32'd4, 32'd4, 8'h00, 1'b0, 1'b0), 0, '0);
        for (int i = 0; i < 5; i++)
            add_row(mk(bctt_pkg::FUNC_READ, 32'd4, 32'd4, 8'hA5, 1'b1, i == 4), 0, '0);
        add_row(mk(bctt_pkg::FUNC_ZERO, 32'd4, 32'd4, 8'h00, 1'b1, 1'b1), 1,
                res(bctt_pkg::FUNC_ZERO, 11'd0));
        add_row(mk(bctt_pkg::FUNC_TRUNC, 32'd8, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1), 1,
                res(bctt_pkg::FUNC_TRUNC, 11'd0));

        foreach (rows[r]) begin
            if (r == 2) begin
                wait_idle();
                set_reg(bctt_pkg::CFG_BLOCK_SHIFT, 32'd2);
                set_reg(bctt_pkg::CFG_CRC_SEED, 32'hFFFF_FFFF);
                set_reg(bctt_pkg::CFG_ZERO_CRC, 32'h1234_5678);
            end
            send_item(rows[r].it, rows[r].typed, rows[r].want);
        end

        while (items_sent < 500) begin
            wait_idle();
            set_reg(bctt_pkg::CFG_BLOCK_SHIFT, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0,
                                                shift_plan[phases % 10]});
            case (phases % 4)
                0: set_reg(bctt_pkg::CFG_CRC_SEED, 32'd0);
                1: set_reg(bctt_pkg::CFG_CRC_SEED, 32'hFFFF_FFFF);
                default: set_reg(bctt_pkg::CFG_CRC_SEED, $urandom);
            endcase
            set_reg(bctt_pkg::CFG_ZERO_CRC, (phases % 3 == 0) ? 32'hFFFF_FFFF : $urandom);
            have_write = 0;
            phases++;
            for (int target = items_sent + 55; items_sent < target;) begin
                if (phases == 3 && items_sent >= target - 40 && items_sent < target - 37)
                    hold_req = 1;
                random_request();
            end
        end
        wait_idle();

        $display("Ran %0d items in %0d configuration phases; %0d results checked.",
                 items_sent, phases, results_seen);
        $display("Covered write, read verify, zero and truncate with block shifts 0 to 16.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
